[hdl/fsrhs_pkg.sv]
// ----------------------------------------------------------------------------
// fsrhs_pkg
// shared types, codes and the micro-program of the submesh rhs block
// ----------------------------------------------------------------------------
`default_nettype none

package fsrhs_pkg;

  localparam int MAX_NODES = 32;
  localparam int FRAC_BITS = 16;

  localparam logic [31:0] Q_ONE  = 32'(64'd1 << FRAC_BITS);
  localparam logic [31:0] Q_HALF = 32'(64'd1 << (FRAC_BITS - 1));

  // function codes of input items
  localparam logic [2:0] FN_VEL  = 3'd0;
  localparam logic [2:0] FN_CGR  = 3'd1;
  localparam logic [2:0] FN_VGR  = 3'd2;
  localparam logic [2:0] FN_D2   = 3'd3;
  localparam logic [2:0] FN_PRS  = 3'd4;
  localparam logic [2:0] FN_WV   = 3'd5;
  localparam logic [2:0] FN_NODE = 3'd6;

  // configuration register indexes
  localparam logic [2:0] CFG_THV  = 3'd0;
  localparam logic [2:0] CFG_THP  = 3'd1;
  localparam logic [2:0] CFG_CF   = 3'd2;
  localparam logic [2:0] CFG_PEN  = 3'd3;
  localparam logic [2:0] CFG_SGV  = 3'd4;
  localparam logic [2:0] CFG_VEN  = 3'd5;
  localparam logic [2:0] CFG_COLB = 3'd6;
  localparam logic [2:0] CFG_HOEN = 3'd7;

  localparam logic [1:0] CF_BETA_ONE  = 2'd1;
  localparam logic [1:0] CF_BETA_HALF = 2'd2;

  localparam logic [1:0] COMP_NONE = 2'd3;
  localparam logic [1:0] COL_LAST  = 2'd2;

  typedef enum logic [1:0] {OP_NOP, OP_MUL, OP_ADD, OP_SUB} op_t;

  typedef enum logic [4:0] {
    S_ZERO, S_N, S_DN, S_UN, S_UT, S_UC, S_GC, S_GV, S_D2, S_GP, S_DG,
    S_FAC, S_VISC, S_THV, S_THP, S_SGV, S_BETA, S_T0, S_T1, S_INC,
    S_FSR, S_FPR, S_CB, S_CC, S_CON
  } src_t;

  typedef enum logic [2:0] {D_T0, D_T1, D_INC, D_FSR, D_FPR, D_CB, D_CC, D_CON} dst_t;

  typedef enum logic [2:0] {G_ALL, G_VEL, G_DIV, G_VIS, G_HO, G_PRS} grp_t;

  typedef struct packed {
    op_t        op;
    src_t       sa;
    src_t       sb;
    dst_t       dst;
    logic [1:0] j;
    grp_t       grp;
  } uop_t;

  typedef struct packed {
    logic        en;
    logic [2:0]  func;
    logic [1:0]  comp;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } ld_t;

  localparam logic [5:0] PC_COL  = 6'd10;
  localparam logic [5:0] PC_LAST = 6'd39;

  function automatic uop_t uop(input logic [5:0] pc);
    uop_t u;
    u = '{OP_NOP, S_ZERO, S_ZERO, D_T0, 2'd0, G_ALL};
    case (pc)
      6'd0:  u = '{OP_MUL, S_FAC,  S_THV,  D_FSR, 2'd0, G_ALL};
      6'd1:  u = '{OP_MUL, S_FAC,  S_THP,  D_FPR, 2'd0, G_ALL};
      6'd2:  u = '{OP_ADD, S_DG,   S_ZERO, D_T0,  2'd0, G_DIV};
      6'd3:  u = '{OP_ADD, S_T0,   S_DG,   D_T0,  2'd1, G_DIV};
      6'd4:  u = '{OP_ADD, S_T0,   S_DG,   D_T0,  2'd2, G_DIV};
      6'd5:  u = '{OP_MUL, S_BETA, S_T0,   D_T0,  2'd0, G_DIV};
      6'd6:  u = '{OP_MUL, S_T0,   S_FSR,  D_CB,  2'd0, G_DIV};
      6'd7:  u = '{OP_ADD, S_VISC, S_SGV,  D_T1,  2'd0, G_VIS};
      6'd8:  u = '{OP_MUL, S_FSR,  S_T1,   D_CC,  2'd0, G_VIS};
      6'd9:  u = '{OP_MUL, S_VISC, S_FSR,  D_CON, 2'd0, G_HO};
      // per column from here on
      6'd10: u = '{OP_MUL, S_UT,   S_FAC,  D_T0,  2'd0, G_ALL};
      6'd11: u = '{OP_MUL, S_N,    S_T0,   D_INC, 2'd0, G_ALL};
      6'd12: u = '{OP_MUL, S_UC,   S_GC,   D_T0,  2'd0, G_VEL};
      6'd13: u = '{OP_MUL, S_UC,   S_GC,   D_T1,  2'd1, G_VEL};
      6'd14: u = '{OP_ADD, S_T0,   S_T1,   D_T0,  2'd0, G_VEL};
      6'd15: u = '{OP_MUL, S_UC,   S_GC,   D_T1,  2'd2, G_VEL};
      6'd16: u = '{OP_ADD, S_T0,   S_T1,   D_T0,  2'd0, G_VEL};
      6'd17: u = '{OP_MUL, S_T0,   S_FSR,  D_T0,  2'd0, G_VEL};
      6'd18: u = '{OP_MUL, S_N,    S_T0,   D_T0,  2'd0, G_VEL};
      6'd19: u = '{OP_SUB, S_INC,  S_T0,   D_INC, 2'd0, G_VEL};
      6'd20: u = '{OP_MUL, S_UN,   S_CB,   D_T0,  2'd0, G_DIV};
      6'd21: u = '{OP_MUL, S_N,    S_T0,   D_T0,  2'd0, G_DIV};
      6'd22: u = '{OP_SUB, S_INC,  S_T0,   D_INC, 2'd0, G_DIV};
      6'd23: u = '{OP_MUL, S_DN,   S_GV,   D_T0,  2'd0, G_VIS};
      6'd24: u = '{OP_MUL, S_DN,   S_GV,   D_T1,  2'd1, G_VIS};
      6'd25: u = '{OP_ADD, S_T0,   S_T1,   D_T0,  2'd0, G_VIS};
      6'd26: u = '{OP_MUL, S_DN,   S_GV,   D_T1,  2'd2, G_VIS};
      6'd27: u = '{OP_ADD, S_T0,   S_T1,   D_T0,  2'd0, G_VIS};
      6'd28: u = '{OP_MUL, S_T0,   S_CC,   D_T0,  2'd0, G_VIS};
      6'd29: u = '{OP_SUB, S_INC,  S_T0,   D_INC, 2'd0, G_VIS};
      6'd30: u = '{OP_ADD, S_D2,   S_ZERO, D_T0,  2'd0, G_HO};
      6'd31: u = '{OP_ADD, S_T0,   S_D2,   D_T0,  2'd1, G_HO};
      6'd32: u = '{OP_ADD, S_T0,   S_D2,   D_T0,  2'd2, G_HO};
      6'd33: u = '{OP_MUL, S_T0,   S_CON,  D_T0,  2'd0, G_HO};
      6'd34: u = '{OP_MUL, S_N,    S_T0,   D_T0,  2'd0, G_HO};
      6'd35: u = '{OP_ADD, S_INC,  S_T0,   D_INC, 2'd0, G_HO};
      6'd36: u = '{OP_MUL, S_GP,   S_FPR,  D_T0,  2'd0, G_PRS};
      6'd37: u = '{OP_MUL, S_N,    S_T0,   D_T0,  2'd0, G_PRS};
      6'd38: u = '{OP_SUB, S_INC,  S_T0,   D_INC, 2'd0, G_PRS};
      default: u = '{OP_NOP, S_ZERO, S_ZERO, D_T0, 2'd0, G_ALL};
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

[hdl/fsrhs_alu.sv]
// ----------------------------------------------------------------------------
// fsrhs_alu
// shared fixed-point unit: rounded saturating multiply, saturating add and sub
// ----------------------------------------------------------------------------
`default_nettype none

module fsrhs_alu
  import fsrhs_pkg::*;
(
  input  op_t         op,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);

  localparam logic signed [64:0] RND = 65'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [64:0] MAXV = 65'sd2147483647;
  localparam logic signed [64:0] MINV = -65'sd2147483648;

  logic signed [63:0] prod;
  logic signed [64:0] q;
  logic signed [64:0] r;
  logic signed [32:0] s;

  always_comb begin
    prod = $signed(a) * $signed(b);
    q    = 65'(prod) + RND;
    // floor shift matches the model for both signs
    r    = q >>> FRAC_BITS;
    s    = '0;
    y    = '0;
    case (op)
      OP_MUL: begin
        if (r > MAXV) y = 32'h7fff_ffff;
        else if (r < MINV) y = 32'h8000_0000;
        else y = r[31:0];
      end
      OP_ADD, OP_SUB: begin
        if (op == OP_ADD) s = {a[31], a} + {b[31], b};
        else s = {a[31], a} - {b[31], b};
        if (s[32] != s[31]) y = s[32] ? 32'h8000_0000 : 32'h7fff_ffff;
        else y = s[31:0];
      end
      default: y = '0;
    endcase
  end

endmodule

`default_nettype wire

[hdl/fsrhs_store.sv]
// ----------------------------------------------------------------------------
// fsrhs_store
// integration point data written by load items, two operand read ports
// ----------------------------------------------------------------------------
`default_nettype none

module fsrhs_store
  import fsrhs_pkg::*;
(
  input  logic        clk,
  input  ld_t         ld,
  input  src_t        sel_a,
  input  src_t        sel_b,
  input  logic [1:0]  col,
  input  logic [1:0]  j,
  output logic [31:0] rd_a,
  output logic [31:0] rd_b
);

  logic [31:0] pv_r [9];
  logic [31:0] cg_r [9];
  logic [31:0] vg_r [9];
  logic [31:0] d2_r [9];
  logic [31:0] pd_r [6];
  logic [31:0] wv_r [2];

  logic [3:0] c0, c1, c2, c3;

  always_comb begin
    c0 = 4'(ld.comp);
    c1 = 4'(ld.comp) + 4'd3;
    c2 = 4'(ld.comp) + 4'd6;
    c3 = 4'(ld.comp) * 4'd3;
  end

  always_ff @(posedge clk) begin
    if (ld.en) begin
      case (ld.func)
        FN_VEL: begin
          pv_r[c0] <= ld.a;
          pv_r[c1] <= ld.b;
          pv_r[c2] <= ld.c;
        end
        FN_CGR: begin
          cg_r[c3]        <= ld.a;
          cg_r[c3 + 4'd1] <= ld.b;
          cg_r[c3 + 4'd2] <= ld.c;
        end
        FN_VGR: begin
          vg_r[c0] <= ld.a;
          vg_r[c1] <= ld.b;
          vg_r[c2] <= ld.c;
        end
        FN_D2: begin
          d2_r[c3]        <= ld.a;
          d2_r[c3 + 4'd1] <= ld.b;
          d2_r[c3 + 4'd2] <= ld.c;
        end
        FN_PRS: begin
          pd_r[3'(ld.comp)]        <= ld.a;
          pd_r[3'(ld.comp) + 3'd3] <= ld.b;
        end
        FN_WV: begin
          wv_r[0] <= ld.a;
          wv_r[1] <= ld.b;
        end
        default: ;
      endcase
    end
  end

  function automatic logic [31:0] rd(input src_t s, input logic [1:0] c,
                                     input logic [1:0] k);
    logic [3:0] cj;
    logic [3:0] jc;
    logic [31:0] v;
    cj = 4'(c) * 4'd3 + 4'(k);
    jc = 4'(k) * 4'd3 + 4'(c);
    case (s)
      S_UN:    v = pv_r[4'(c)];
      S_UT:    v = pv_r[4'(c) + 4'd3];
      S_UC:    v = pv_r[4'(k) + 4'd6];
      S_GC:    v = cg_r[cj];
      S_GV:    v = vg_r[jc];
      S_D2:    v = d2_r[cj];
      S_GP:    v = pd_r[3'(c)];
      S_DG:    v = pd_r[3'(k) + 3'd3];
      S_FAC:   v = wv_r[0];
      S_VISC:  v = wv_r[1];
      default: v = '0;
    endcase
    return v;
  endfunction

  assign rd_a = rd(sel_a, col, j);
  assign rd_b = rd(sel_b, col, j);

endmodule

`default_nettype wire

[hdl/fem_submesh_galerkin_rhs.sv]
// ----------------------------------------------------------------------------
// fem_submesh_galerkin_rhs
// galerkin rhs increments of a fluid submesh element per node item
// ----------------------------------------------------------------------------
//  channel | direction | ports
//  in_     | input     | func, component, node_row, value_a..d, last_node
//  out_    | output    | row, first_column, increment_x/y/z, last
//  cfg_    | input     | index, data (always ready)
//
// a node item runs 10 set-up steps plus 30 steps per column (29 operations and
// the column store) on one shared multiply/add unit at one step a cycle, then
// hands over the result; a load item is written to the point store when taken
// in_ready is low while a node item runs and until its result has a free slot
// loads are still taken while a finished result waits on out_ready
// synchronous active-low reset sets control state and configuration registers only
// ----------------------------------------------------------------------------
`default_nettype none

module fem_submesh_galerkin_rhs
  import fsrhs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_func,
  input  logic [1:0]  in_component,
  input  logic [4:0]  in_node_row,
  input  logic [31:0] in_value_a,
  input  logic [31:0] in_value_b,
  input  logic [31:0] in_value_c,
  input  logic [31:0] in_value_d,
  input  logic        in_last_node,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_row,
  output logic [7:0]  out_first_column,
  output logic [31:0] out_increment_x,
  output logic [31:0] out_increment_y,
  output logic [31:0] out_increment_z,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [31:0] thv_r, thp_r, sgv_r;
  logic [1:0]  cf_r;
  logic        pen_r, ven_r, hoen_r;
  logic [7:0]  colb_r;

  logic [31:0] sh_r [4];
  logic [4:0]  row_r;
  logic        last_r;
  logic [5:0]  pc_r;
  logic [1:0]  col_r;
  logic [31:0] t0_r, t1_r, inc_r, fsr_r, fpr_r, cb_r, cc_r, con_r;
  logic [31:0] res_r [3];
  logic        out_valid_r;

  uop_t        u;
  ld_t         ld;
  logic [31:0] st_a, st_b, opa, opb, y;
  logic        en;
  logic        in_acc, is_node;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid & in_ready;
  assign is_node   = (in_func == FN_NODE) && ({2'b00, in_node_row} < 7'(MAX_NODES));

  always_comb begin
    ld.en   = in_acc && (in_func != FN_NODE) && (in_component != COMP_NONE);
    ld.func = in_func;
    ld.comp = in_component;
    ld.a    = in_value_a;
    ld.b    = in_value_b;
    ld.c    = in_value_c;
  end

  assign u = uop(pc_r);

  fsrhs_store u_store (
    .clk   (clk),
    .ld    (ld),
    .sel_a (u.sa),
    .sel_b (u.sb),
    .col   (col_r),
    .j     (u.j),
    .rd_a  (st_a),
    .rd_b  (st_b)
  );

  function automatic logic [31:0] opnd(input src_t s, input logic [31:0] sv,
                                       input logic [31:0] dn);
    logic [31:0] v;
    case (s)
      S_ZERO: v = '0;
      S_N:    v = sh_r[0];
      S_DN:   v = dn;
      S_THV:  v = thv_r;
      S_THP:  v = thp_r;
      S_SGV:  v = sgv_r;
      S_BETA: v = (cf_r == CF_BETA_ONE) ? Q_ONE : Q_HALF;
      S_T0:   v = t0_r;
      S_T1:   v = t1_r;
      S_INC:  v = inc_r;
      S_FSR:  v = fsr_r;
      S_FPR:  v = fpr_r;
      S_CB:   v = cb_r;
      S_CC:   v = cc_r;
      S_CON:  v = con_r;
      default: v = sv;
    endcase
    return v;
  endfunction

  logic [31:0] dn;
  always_comb begin
    case (u.j)
      2'd0:    dn = sh_r[1];
      2'd1:    dn = sh_r[2];
      default: dn = sh_r[3];
    endcase
    opa = opnd(u.sa, st_a, dn);
    opb = opnd(u.sb, st_b, dn);
  end

  fsrhs_alu u_alu (
    .op (u.op),
    .a  (opa),
    .b  (opb),
    .y  (y)
  );

  logic velon;
  always_comb begin
    velon = (thv_r != '0);
    case (u.grp)
      G_ALL:   en = 1'b1;
      G_VEL:   en = velon;
      G_DIV:   en = velon && (cf_r == CF_BETA_ONE || cf_r == CF_BETA_HALF);
      G_VIS:   en = velon && ven_r;
      G_HO:    en = velon && hoen_r;
      G_PRS:   en = (thp_r != '0) && pen_r;
      default: en = 1'b0;
    endcase
    en = en && (state_r == ST_RUN) && (u.op != OP_NOP);
  end

  logic out_free;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_acc && is_node) state_nxt = ST_RUN;
      ST_RUN:  if (pc_r == PC_LAST && col_r == COL_LAST) state_nxt = ST_DONE;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      pc_r        <= '0;
      col_r       <= '0;
      thv_r       <= '0;
      thp_r       <= '0;
      sgv_r       <= '0;
      cf_r        <= '0;
      pen_r       <= 1'b0;
      ven_r       <= 1'b1;
      hoen_r      <= 1'b0;
      colb_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_THV:  thv_r  <= cfg_data;
          CFG_THP:  thp_r  <= cfg_data;
          CFG_CF:   cf_r   <= cfg_data[1:0];
          CFG_PEN:  pen_r  <= cfg_data[0];
          CFG_SGV:  sgv_r  <= cfg_data;
          CFG_VEN:  ven_r  <= cfg_data[0];
          CFG_COLB: colb_r <= cfg_data[7:0];
          CFG_HOEN: hoen_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (state_r == ST_IDLE) begin
        pc_r  <= '0;
        col_r <= '0;
      end else if (state_r == ST_RUN) begin
        if (pc_r == PC_LAST) begin
          pc_r  <= PC_COL;
          col_r <= col_r + 2'd1;
        end else begin
          pc_r <= pc_r + 6'd1;
        end
      end
      if (state_r == ST_DONE && out_free) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc && is_node) begin
      sh_r[0] <= in_value_a;
      sh_r[1] <= in_value_b;
      sh_r[2] <= in_value_c;
      sh_r[3] <= in_value_d;
      row_r   <= in_node_row;
      last_r  <= in_last_node;
    end
    if (en) begin
      case (u.dst)
        D_T0:    t0_r  <= y;
        D_T1:    t1_r  <= y;
        D_INC:   inc_r <= y;
        D_FSR:   fsr_r <= y;
        D_FPR:   fpr_r <= y;
        D_CB:    cb_r  <= y;
        D_CC:    cc_r  <= y;
        default: con_r <= y;
      endcase
    end
    if (state_r == ST_RUN && pc_r == PC_LAST) res_r[col_r] <= inc_r;
    if (state_r == ST_DONE && out_free) begin
      out_row          <= row_r;
      out_first_column <= colb_r;
      out_increment_x  <= res_r[0];
      out_increment_y  <= res_r[1];
      out_increment_z  <= res_r[2];
      out_last         <= last_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

[verif/tb_fem_submesh_galerkin_rhs.sv]
// ----------------------------------------------------------------------------
// tb_fem_submesh_galerkin_rhs
// drives point loads and node items through the submesh rhs block, predicts
// each node's three column increments in fixed point and checks every result
// ----------------------------------------------------------------------------
`default_nettype none

module tb_fem_submesh_galerkin_rhs;
  import fsrhs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 2000000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_func;
  logic [1:0]  in_component;
  logic [4:0]  in_node_row;
  logic [31:0] in_value_a;
  logic [31:0] in_value_b;
  logic [31:0] in_value_c;
  logic [31:0] in_value_d;
  logic        in_last_node;
  logic        out_valid;
  logic        out_ready;
  logic [4:0]  out_row;
  logic [7:0]  out_first_column;
  logic [31:0] out_increment_x;
  logic [31:0] out_increment_y;
  logic [31:0] out_increment_z;
  logic        out_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  typedef struct packed {
    logic [4:0]  row;
    logic [7:0]  col;
    logic [31:0] inc_x;
    logic [31:0] inc_y;
    logic [31:0] inc_z;
    logic        last;
  } node_result_t;

  // mirror of point data and registers
  logic signed [31:0] vel_m [9];
  logic signed [31:0] cgrad_m [9];
  logic signed [31:0] vgrad_m [9];
  logic signed [31:0] d2_m [9];
  logic signed [31:0] prsdiv_m [6];
  logic signed [31:0] fac_m, visc_m;
  logic signed [31:0] thv_r, thp_r, sgv_r;
  logic [1:0]         cform_r;
  logic               pen_r, ven_r, hoen_r;
  logic [7:0]         colb_r;

  node_result_t expected_q[$];
  int  n_errors;
  int  cycle_cnt;
  int  send_idle_pct, recv_idle_pct;
  bit  hold_off;

  fem_submesh_galerkin_rhs u_top (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic signed [31:0] sat(input logic signed [63:0] x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  function automatic logic signed [31:0] qm(input logic signed [31:0] a,
                                             input logic signed [31:0] b);
    logic signed [63:0] q;
    logic signed [63:0] r;
    q = 64'(a) * 64'(b) + (64'sd1 <<< (FRAC_BITS - 1));
    // arithmetic shift floors, matching rounding half up
    r = q >>> FRAC_BITS;
    return sat(r);
  endfunction

  function automatic logic signed [31:0] qa(input logic signed [31:0] a,
                                             input logic signed [31:0] b);
    return sat(64'(a) + 64'(b));
  endfunction

  function automatic logic signed [31:0] qs(input logic signed [31:0] a,
                                             input logic signed [31:0] b);
    return sat(64'(a) - 64'(b));
  endfunction

  function automatic logic signed [31:0] column_rhs(input int c,
      input logic signed [31:0] n, input logic signed [31:0] dx,
      input logic signed [31:0] dy, input logic signed [31:0] dz);
    logic signed [31:0] facsr, facpr, inc, s, dv, beta, g, d;
    logic signed [31:0] dn [3];
    dn[0] = dx; dn[1] = dy; dn[2] = dz;
    facsr = qm(fac_m, thv_r);
    facpr = qm(fac_m, thp_r);
    inc = qm(n, qm(vel_m[3 + c], fac_m));
    if (thv_r != 0) begin
      s = 0;
      for (int j = 0; j < 3; j++) s = qa(s, qm(vel_m[6 + j], cgrad_m[c * 3 + j]));
      inc = qs(inc, qm(n, qm(s, facsr)));
      if (cform_r == CF_BETA_ONE || cform_r == CF_BETA_HALF) begin
        dv = qa(qa(prsdiv_m[3], prsdiv_m[4]), prsdiv_m[5]);
        beta = (cform_r == CF_BETA_ONE) ? Q_ONE : Q_HALF;
        inc = qs(inc, qm(n, qm(vel_m[c], qm(qm(beta, dv), facsr))));
      end
      if (ven_r) begin
        g = 0;
        for (int j = 0; j < 3; j++) g = qa(g, qm(dn[j], vgrad_m[j * 3 + c]));
        inc = qs(inc, qm(g, qm(facsr, qa(visc_m, sgv_r))));
      end
      if (hoen_r) begin
        d = qa(qa(d2_m[c * 3], d2_m[c * 3 + 1]), d2_m[c * 3 + 2]);
        inc = qa(inc, qm(n, qm(d, qm(facsr, visc_m))));
      end
    end
    if (thp_r != 0 && pen_r) inc = qs(inc, qm(n, qm(prsdiv_m[c], facpr)));
    return inc;
  endfunction

  // update mirror for an accepted item, queue a result for node items
  task automatic predict_item(input logic [2:0] f, input logic [1:0] c,
      input logic [4:0] r, input logic [31:0] a, input logic [31:0] b,
      input logic [31:0] cv, input logic [31:0] d, input logic l);
    node_result_t e;
    if (f == FN_NODE) begin
      if (r < MAX_NODES) begin
        e.row = r; e.col = colb_r; e.last = l;
        e.inc_x = column_rhs(0, a, b, cv, d);
        e.inc_y = column_rhs(1, a, b, cv, d);
        e.inc_z = column_rhs(2, a, b, cv, d);
        expected_q.push_back(e);
      end
      return;
    end
    if (c == COMP_NONE) return;
    case (f)
      FN_VEL: begin vel_m[c] = a; vel_m[3 + c] = b; vel_m[6 + c] = cv; end
      FN_CGR: begin cgrad_m[c * 3] = a; cgrad_m[c * 3 + 1] = b; cgrad_m[c * 3 + 2] = cv; end
      FN_VGR: begin vgrad_m[c] = a; vgrad_m[3 + c] = b; vgrad_m[6 + c] = cv; end
      FN_D2:  begin d2_m[c * 3] = a; d2_m[c * 3 + 1] = b; d2_m[c * 3 + 2] = cv; end
      FN_PRS: begin prsdiv_m[c] = a; prsdiv_m[3 + c] = b; end
      FN_WV:  begin fac_m = a; visc_m = b; end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_cnt);
    n_errors++;
  endtask

  // receiver side and checker
  always @(negedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    node_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected item", out_increment_x, 0);
      end else begin
        e = expected_q.pop_front();
        if (out_row !== e.row) report_mismatch("row", out_row, e.row);
        if (out_first_column !== e.col) report_mismatch("column", out_first_column, e.col);
        if (out_increment_x !== e.inc_x) report_mismatch("inc_x", out_increment_x, e.inc_x);
        if (out_increment_y !== e.inc_y) report_mismatch("inc_y", out_increment_y, e.inc_y);
        if (out_increment_z !== e.inc_z) report_mismatch("inc_z", out_increment_z, e.inc_z);
        if (out_last !== e.last) report_mismatch("last", out_last, e.last);
      end
    end
  end

  // valid stays high after the item until the next item or an idle cycle
  task automatic send_item(input logic [2:0] f, input logic [1:0] c,
      input logic [4:0] r, input logic [31:0] a, input logic [31:0] b,
      input logic [31:0] cv, input logic [31:0] d, input logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1; in_func <= f; in_component <= c; in_node_row <= r;
    in_value_a <= a; in_value_b <= b; in_value_c <= cv; in_value_d <= d;
    in_last_node <= l;
    do @(posedge clk); while (!in_ready);
    predict_item(f, c, r, a, b, cv, d, l);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    // let the block settle before any configuration change
    repeat (150) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_THV:  thv_r = val;
      CFG_THP:  thp_r = val;
      CFG_CF:   cform_r = val[1:0];
      CFG_PEN:  pen_r = val[0];
      CFG_SGV:  sgv_r = val;
      CFG_VEN:  ven_r = val[0];
      CFG_COLB: colb_r = val[7:0];
      CFG_HOEN: hoen_r = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // mostly modest magnitudes so terms do not all saturate, sometimes anything
  function automatic logic [31:0] rand_q();
    case ($urandom_range(9))
      0: return $urandom();
      1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      2: return 32'($signed($urandom_range(65535)) - 32768);
      default: return 32'($signed($urandom_range(32'h3ffff)) - 32'sh20000);
    endcase
  endfunction

  task automatic load_point();
    for (int c = 0; c < 3; c++) begin
      send_item(FN_VEL, 2'(c), 5'd0, rand_q(), rand_q(), rand_q(), $urandom(), 1'b0);
      send_item(FN_CGR, 2'(c), 5'd0, rand_q(), rand_q(), rand_q(), $urandom(), 1'b0);
      send_item(FN_VGR, 2'(c), 5'd0, rand_q(), rand_q(), rand_q(), $urandom(), 1'b0);
      send_item(FN_D2,  2'(c), 5'd0, rand_q(), rand_q(), rand_q(), $urandom(), 1'b0);
      send_item(FN_PRS, 2'(c), 5'd0, rand_q(), rand_q(), 32'd0, $urandom(), 1'b0);
    end
    send_item(FN_WV, 2'd0, 5'd0, rand_q(), rand_q(), 32'd0, 32'd0, 1'b0);
  endtask

  task automatic random_config();
    write_reg(CFG_THV,  rand_q());
    write_reg(CFG_THP,  $urandom_range(3) == 0 ? 32'h0 : rand_q());
    write_reg(CFG_CF,   $urandom_range(3));
    write_reg(CFG_PEN,  $urandom_range(1));
    write_reg(CFG_SGV,  rand_q());
    write_reg(CFG_VEN,  $urandom_range(1));
    write_reg(CFG_COLB, $urandom_range(255));
    write_reg(CFG_HOEN, $urandom_range(1));
  endtask

  task automatic test_directed();
    write_reg(CFG_THV, Q_ONE);
    write_reg(CFG_THP, Q_HALF);
    write_reg(CFG_CF, 32'(CF_BETA_ONE));
    write_reg(CFG_PEN, 32'd1);
    write_reg(CFG_SGV, 32'h80000000);
    write_reg(CFG_VEN, 32'd1);
    write_reg(CFG_COLB, 32'hff);
    write_reg(CFG_HOEN, 32'd1);
    load_point();
    // ignored items: component three and function seven
    send_item(FN_WV, COMP_NONE, 5'd0, 32'h7fffffff, 32'h7fffffff, 32'd0, 32'd0, 1'b0);
    send_item(3'd7, 2'd0, 5'd0, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
              1'b1);
    send_item(FN_NODE, 2'd0, 5'd0, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
              1'b0);
    send_item(FN_NODE, 2'd0, 5'd31, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
              1'b1);
    send_item(FN_NODE, 2'd3, 5'd5, Q_ONE, 32'd0, 32'd0, 32'd0, 1'b0);
    wait_drained();
    write_reg(CFG_CF, 32'd3);
    write_reg(CFG_COLB, 32'd0);
    send_item(FN_NODE, 2'd0, 5'd10, Q_HALF, Q_ONE, Q_ONE, Q_ONE, 1'b1);
    wait_drained();
    write_reg(CFG_CF, 32'(CF_BETA_HALF));
    write_reg(CFG_THV, 32'h80000000);
    write_reg(CFG_THP, 32'h7fffffff);
    send_item(FN_NODE, 2'd0, 5'd3, 32'hffffffff, 32'h00000001, 32'hffff0000, 32'h0000ffff,
              1'b1);
    wait_drained();
    write_reg(CFG_THV, 32'd0);
    send_item(FN_NODE, 2'd0, 5'd7, Q_ONE, Q_ONE, Q_ONE, Q_ONE, 1'b1);
    wait_drained();
  endtask

  task automatic test_random(input int n_items);
    int sent, nodes;
    sent = 0;
    while (sent < n_items) begin
      wait_drained();
      if ($urandom_range(3) == 0) random_config();
      load_point();
      sent += 16;
      nodes = $urandom_range(1, 8);
      for (int i = 0; i < nodes; i++) begin
        send_item(FN_NODE, 2'($urandom_range(3)), 5'($urandom()), rand_q(), rand_q(),
                  rand_q(), rand_q(), i == nodes - 1);
        sent++;
      end
      if ($urandom_range(7) == 0) begin
        send_item($urandom_range(1) ? 3'd7 : FN_VEL, COMP_NONE, 5'($urandom()), $urandom(),
                  $urandom(), $urandom(), $urandom(), 1'($urandom_range(1)));
        sent++;
      end
    end
    wait_drained();
  endtask

  // receiver stalls long while node items keep coming
  task automatic test_backpressure();
    load_point();
    hold_off = 1'b1;
    fork
      begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < 800) begin
          @(posedge clk);
          stall_cycles++;
        end
        hold_off = 1'b0;
      end
      for (int i = 0; i < 6; i++)
        send_item(FN_NODE, 2'd0, 5'(i), rand_q(), rand_q(), rand_q(), rand_q(), i == 5);
    join
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0; in_valid = 1'b0; in_func = '0; in_component = '0;
    in_node_row = '0; in_value_a = '0; in_value_b = '0; in_value_c = '0;
    in_value_d = '0; in_last_node = 1'b0; cfg_valid = 1'b0; cfg_index = '0;
    cfg_data = '0; hold_off = 1'b0; n_errors = 0; cycle_cnt = 0;
    send_idle_pct = 0; recv_idle_pct = 0;
    thv_r = 0; thp_r = 0; cform_r = 0; pen_r = 0; sgv_r = 0; ven_r = 1;
    colb_r = 0; hoen_r = 0; fac_m = 0; visc_m = 0;
    for (int i = 0; i < 9; i++) begin
      vel_m[i] = 0; cgrad_m[i] = 0; vgrad_m[i] = 0; d2_m[i] = 0;
    end
    for (int i = 0; i < 6; i++) prsdiv_m[i] = 0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    send_idle_pct = 38; recv_idle_pct = 58;
    test_random(370);
    test_backpressure();
    send_idle_pct = 58; recv_idle_pct = 38;
    test_random(370);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(370);
    repeat (150) @(negedge clk);

    if (n_errors == 0 && expected_q.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire
